### rtl/core/tksel_pkg.sv
// ----------------------------------------------------------------------------
// tksel_pkg
// shared types and constants of the streaming top-k selector
// ----------------------------------------------------------------------------
package tksel_pkg;

  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam int KSEL_W     = 5;

  localparam logic [REG_IDX_W-1:0] REG_K_SELECT = '0;
  localparam logic [KSEL_W-1:0]    KSEL_RESET   = KSEL_W'(1);

  // compare flags one cell hands to its neighbours
  typedef struct packed {
    logic gt;  // stored value above the request value, entry in use
    logic lt;  // stored value below the request value, entry within rank
  } tksel_flags_t;

endpackage

### rtl/core/tksel_ifs.sv
// ----------------------------------------------------------------------------
// tksel channel interfaces
// valid/ready channels for sample requests and results
// ----------------------------------------------------------------------------
interface tksel_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] sample_value;
  logic                         last_item;

  modport source (output valid, output sample_value, output last_item, input ready);
  modport sink   (input valid, input sample_value, input last_item, output ready);
endinterface

interface tksel_out_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] kth_value;
  logic                         too_few;

  modport source (output valid, output kth_value, output too_few, input ready);
  modport sink   (input valid, input kth_value, input too_few, output ready);
endinterface

### rtl/core/tksel_cell.sv
// ----------------------------------------------------------------------------
// tksel_cell
// one entry of the ascending buffer: compares and shifts with its neighbours
// ----------------------------------------------------------------------------
module tksel_cell
  import tksel_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         fill_mode,
  input  logic                         in_use,
  input  logic                         at_fill,
  input  logic                         in_rank,
  input  logic signed [VALUE_BITS-1:0] sample,
  input  logic signed [VALUE_BITS-1:0] left_val,
  input  tksel_flags_t                 left_flags,
  input  logic signed [VALUE_BITS-1:0] right_val,
  input  tksel_flags_t                 right_flags,
  output logic signed [VALUE_BITS-1:0] val,
  output logic signed [VALUE_BITS-1:0] val_nxt,
  output tksel_flags_t                 flags
);

  logic signed [VALUE_BITS-1:0] val_r;

  always_comb begin
    flags.gt = in_use && (val_r > sample);
    flags.lt = in_rank && (val_r < sample);
    if (fill_mode) begin
      if (left_flags.gt) begin
        val_nxt = left_val;
      end else if (flags.gt || at_fill) begin
        val_nxt = sample;
      end else begin
        val_nxt = val_r;
      end
    end else begin
      if (right_flags.lt) begin
        val_nxt = right_val;
      end else if (flags.lt) begin
        val_nxt = sample;
      end else begin
        val_nxt = val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

### rtl/core/streaming_top_k_selector_unit.sv
// ----------------------------------------------------------------------------
// streaming_top_k_selector_unit
// keeps the k largest samples of a set in a sorted cell row, reports the k-th
// ----------------------------------------------------------------------------
// result: valid in the cycle after the request marked last is accepted
// throughput: one request per cycle, every cell compares and shifts in parallel
// a waiting result stalls requests only while it is not taken
// reset: synchronous, active low; clears fill count and result valid, rank returns to 1
// buffer cells are not reset, entries are written before they are read
module streaming_top_k_selector_unit
  import tksel_pkg::*;
#(
  parameter int K_MAX      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tksel_in_if.sink              in_ch,
  tksel_out_if.source           out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNT_W = $clog2(K_MAX + 1);
  localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [KSEL_W-1:0] k_select_r;
  logic [CNT_W-1:0]  items_seen_r, items_seen_nxt;
  logic [CNT_W-1:0]  eff_k;
  logic [CNT_W-1:0]  seen_after;
  logic              out_valid_r, out_valid_nxt;
  logic signed [VALUE_BITS-1:0] kth_r, kth_nxt;
  logic              too_few_r, too_few_nxt;
  logic              accept, fill_mode, cfg_wr, reg_hit;

  logic signed [VALUE_BITS-1:0] cell_val [K_MAX];
  logic signed [VALUE_BITS-1:0] cell_nxt [K_MAX];
  tksel_flags_t                 cell_flags [K_MAX];

  // configuration port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_K_SELECT);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = reg_hit ? APB_DATA_W'(k_select_r) : '0;

  always_comb begin
    if (k_select_r == '0) begin
      eff_k = CNT_W'(1);
    end else if (32'(k_select_r) > K_MAX) begin
      eff_k = CNT_W'(K_MAX);
    end else begin
      eff_k = CNT_W'(k_select_r);
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign fill_mode   = items_seen_r < eff_k;
  assign seen_after  = fill_mode ? items_seen_r + CNT_W'(1) : items_seen_r;

  // cell row
  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] lv, rv;
    tksel_flags_t                 lf, rf;
    if (i == 0) begin : g_lo
      assign lv = '0;
      assign lf = '0;
    end else begin : g_lo
      assign lv = cell_val[i-1];
      assign lf = cell_flags[i-1];
    end
    if (i == K_MAX - 1) begin : g_hi
      assign rv = '0;
      assign rf = '0;
    end else begin : g_hi
      assign rv = cell_val[i+1];
      assign rf = cell_flags[i+1];
    end
    tksel_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .load        (accept),
      .fill_mode   (fill_mode),
      .in_use      (32'(items_seen_r) > i),
      .at_fill     (32'(items_seen_r) == i),
      .in_rank     (32'(eff_k) > i),
      .sample      (in_ch.sample_value),
      .left_val    (lv),
      .left_flags  (lf),
      .right_val   (rv),
      .right_flags (rf),
      .val         (cell_val[i]),
      .val_nxt     (cell_nxt[i]),
      .flags       (cell_flags[i])
    );
  end

  always_comb begin
    items_seen_nxt = items_seen_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    kth_nxt        = kth_r;
    too_few_nxt    = too_few_r;
    if (accept) begin
      items_seen_nxt = in_ch.last_item ? '0 : seen_after;
      if (in_ch.last_item) begin
        out_valid_nxt = 1'b1;
        too_few_nxt   = seen_after < eff_k;
        kth_nxt       = (seen_after < eff_k) ? MOST_NEG : cell_nxt[0];
      end
    end
    if (cfg_wr && reg_hit) begin
      items_seen_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_select_r   <= KSEL_RESET;
      items_seen_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr && reg_hit) begin
        k_select_r <= pwdata[KSEL_W-1:0];
      end
      items_seen_r <= items_seen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    kth_r     <= kth_nxt;
    too_few_r <= too_few_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kth_value = kth_r;
  assign out_ch.too_few   = too_few_r;

  // checks
  a_count_in_rank: assert property (@(posedge clk) disable iff (!rst_n)
    items_seen_r <= eff_k)
    else $error("fill count above rank");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.last_item |=> items_seen_r == '0)
    else $error("fill count not cleared after last request");

  a_short_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && too_few_r |-> kth_r == MOST_NEG)
    else $error("short set result not most negative");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.last_item |=> out_valid_r)
    else $error("result missing after last request");

endmodule
